>>> rtl/core/half_pel_motion_compensation_defines.svh
// Assertion helpers used by the checker file.
`ifndef HALF_PEL_MOTION_COMPENSATION_DEFINES_SVH
`define HALF_PEL_MOTION_COMPENSATION_DEFINES_SVH

// Clocked property, masked while reset is asserted.
`define HPMC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define HPMC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/hpmc_pkg.sv
package hpmc_pkg;

    // Default window limits
    localparam int DEF_MAX_WIDTH  = 16;
    localparam int DEF_MAX_HEIGHT = 16;

    // Field widths
    localparam int PIX_W  = 8;
    localparam int RES_W  = 9;
    localparam int CFG_DW = 5;
    localparam int CFG_IW = 3;

    localparam logic [CFG_DW-1:0] BLOCK_SIZE_RST = 5'd16;

    typedef logic [PIX_W-1:0] t_pix;

    // Configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        CFG_HALF_X       = 3'd0,
        CFG_HALF_Y       = 3'd1,
        CFG_AVG_CUR      = 3'd2,
        CFG_RESID_MODE   = 3'd3,
        CFG_BLOCK_WIDTH  = 3'd4,
        CFG_BLOCK_HEIGHT = 3'd5
    } t_cfg_idx;

    // Effective mode seen by the prediction datapath
    typedef struct packed {
        logic half_x;
        logic half_y;
        logic avg_cur;
        logic resid;
    } t_pred_mode;

    // Per-request control into the line buffer
    typedef struct packed {
        logic step;
        logic nonres;
        logic end_col;
    } t_lbuf_ctl;

endpackage

>>> rtl/core/hpmc_if.sv
// Request channel: one reference window pixel with its side data
interface hpmc_pix_if
    import hpmc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    t_pix                    ref_pixel;
    t_pix                    current_pixel;
    logic signed [RES_W-1:0] residual;

    modport source (output valid, ref_pixel, current_pixel, residual, input ready);
    modport sink   (input valid, ref_pixel, current_pixel, residual, output ready);
endinterface

// Result channel: one predicted pixel
interface hpmc_pred_if
    import hpmc_pkg::*;
();
    logic valid;
    logic ready;
    t_pix pred_pixel;
    logic block_last;

    modport source (output valid, pred_pixel, block_last, input ready);
    modport sink   (input valid, pred_pixel, block_last, output ready);
endinterface

>>> rtl/core/hpmc_pred.sv
module hpmc_pred
    import hpmc_pkg::*;
(
    input  t_pred_mode              i_mode,
    input  t_pix                    i_tl,
    input  t_pix                    i_tr,
    input  t_pix                    i_bl,
    input  t_pix                    i_ref,
    input  t_pix                    i_cur,
    input  logic signed [RES_W-1:0] i_residual,
    output t_pix                    o_pred
);

    logic [PIX_W+1:0]       sum4;
    logic [PIX_W:0]         sum_x;
    logic [PIX_W:0]         sum_y;
    logic [PIX_W:0]         sum_avg;
    t_pix                   interp;
    logic signed [PIX_W+1:0] recon;

    // Half-pel averages with round-half-up
    assign sum4  = {2'b00, i_tl} + {2'b00, i_tr} + {2'b00, i_bl} + {2'b00, i_ref}
                 + (PIX_W+2)'(2);
    assign sum_x = {1'b0, i_bl} + {1'b0, i_ref} + (PIX_W+1)'(1);
    assign sum_y = {1'b0, i_tr} + {1'b0, i_ref} + (PIX_W+1)'(1);

    always_comb begin
        case ({i_mode.half_x, i_mode.half_y})
            2'b11:   interp = sum4[PIX_W+1:2];
            2'b10:   interp = sum_x[PIX_W:1];
            2'b01:   interp = sum_y[PIX_W:1];
            default: interp = i_ref;
        endcase
    end

    // Optional bidirectional-style average with the current pixel
    assign sum_avg = {1'b0, interp} + {1'b0, i_cur} + (PIX_W+1)'(1);

    // Reconstruction: current + residual, range -256..510
    assign recon = $signed({2'b00, i_cur}) + $signed({i_residual[RES_W-1], i_residual});

    always_comb begin
        if (i_mode.resid) begin
            if (recon[PIX_W+1]) begin
                o_pred = '0;
            end else if (recon[PIX_W]) begin
                o_pred = '1;
            end else begin
                o_pred = recon[PIX_W-1:0];
            end
        end else if (i_mode.avg_cur) begin
            o_pred = sum_avg[PIX_W:1];
        end else begin
            o_pred = interp;
        end
    end

endmodule

>>> rtl/core/hpmc_lbuf.sv
// Line buffer of the previous window row plus the previous pixel.
// The top-right neighbor is prefetched one request ahead from a
// registered-read memory; the top-left one is the previous top-right.
module hpmc_lbuf
    import hpmc_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_lbuf_ctl                           i_ctl,
    input  logic [$clog2(MAX_WIDTH + 1)-1:0]    i_col,
    input  logic [$clog2(MAX_WIDTH + 1)-1:0]    i_col_next,
    input  t_pix                                i_ref,
    output t_pix                                o_tl,
    output t_pix                                o_tr,
    output t_pix                                o_bl
);

    localparam int ROW_DEPTH = MAX_WIDTH + 1;
    localparam int AW        = $clog2(ROW_DEPTH);

    t_pix                 r_mem [ROW_DEPTH];
    logic [ROW_DEPTH-1:0] r_vld;
    t_pix                 r_rd_q;
    logic                 r_rd_vld;
    logic                 r_fwd_vld;
    t_pix                 r_fwd_data;
    logic                 r_pend_vld;
    logic [AW-1:0]        r_pend_addr;
    t_pix                 r_pend_data;
    t_pix                 r_prev_pixel;
    t_pix                 r_tl;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    t_pix                 wr_data;
    logic                 n_fwd_vld;
    t_pix                 n_fwd_data;
    t_pix                 tr;

    // Single write port: the row-end write is parked until the next
    // request, which always sits in column zero and has no delayed write.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pend_addr;
        wr_data = r_pend_data;
        if (i_ctl.step) begin
            if ((i_col == '0) && r_pend_vld) begin
                wr_en = 1'b1;
            end else if (i_ctl.nonres && (i_col != '0)) begin
                wr_en   = 1'b1;
                wr_addr = i_col - AW'(1);
                wr_data = r_prev_pixel;
            end
        end
    end

    // Bypass for entries written in the same cycle as the prefetch
    always_comb begin
        n_fwd_vld  = 1'b0;
        n_fwd_data = wr_data;
        if (i_ctl.nonres && i_ctl.end_col && (i_col == i_col_next)) begin
            n_fwd_vld  = 1'b1;
            n_fwd_data = i_ref;
        end else if (wr_en && (wr_addr == i_col_next)) begin
            n_fwd_vld  = 1'b1;
            n_fwd_data = wr_data;
        end
    end

    assign tr   = r_fwd_vld ? r_fwd_data : (r_rd_vld ? r_rd_q : '0);
    assign o_tr = tr;
    assign o_tl = (i_col == '0) ? '0 : r_tl;
    assign o_bl = r_prev_pixel;

    // Row memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_ctl.step) begin
            r_rd_q <= r_mem[i_col_next];
            r_tl   <= tr;
        end
    end

    // Control state: entry valid bits, bypass, parked write, previous pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_rd_vld     <= 1'b0;
            r_fwd_vld    <= 1'b1;
            r_fwd_data   <= '0;
            r_pend_vld   <= 1'b0;
            r_pend_addr  <= '0;
            r_pend_data  <= '0;
            r_prev_pixel <= '0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_ctl.step) begin
                r_rd_vld   <= r_vld[i_col_next];
                r_fwd_vld  <= n_fwd_vld;
                r_fwd_data <= n_fwd_data;
                if (i_ctl.nonres && i_ctl.end_col) begin
                    r_pend_vld  <= 1'b1;
                    r_pend_addr <= i_col;
                    r_pend_data <= i_ref;
                end else if (i_col == '0) begin
                    r_pend_vld <= 1'b0;
                end
                if (i_ctl.nonres) begin
                    r_prev_pixel <= i_ref;
                end
            end
        end
    end

endmodule

>>> rtl/core/half_pel_motion_compensation.sv
// A result is registered on o_pred in the cycle after its request is accepted.
// Throughput: one request per cycle; a result stalled on o_pred holds off
// new requests until it is taken, and the next request enters in that cycle.
// Reset: synchronous, active low; configuration returns to its defaults,
// counters, previous pixel and row-buffer valid bits clear.
module half_pel_motion_compensation
    import hpmc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    hpmc_pix_if.sink          i_pix,
    hpmc_pred_if.source       o_pred
);

    localparam int AW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int MW  = (AW > RW) ? AW : RW;
    localparam int WW  = ((MW > CFG_DW) ? MW : CFG_DW) + 1;

    // Configuration
    logic              r_half_x;
    logic              r_half_y;
    logic              r_avg_cur;
    logic              r_resid;
    logic [CFG_DW-1:0] r_block_width;
    logic [CFG_DW-1:0] r_block_height;

    // Window position and output register
    logic [AW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic              r_out_vld;
    t_pix              r_pred;
    logic              r_last;

    logic              accept;
    logic              hx;
    logic              hy;
    logic [WW-1:0]     bw;
    logic [WW-1:0]     bh;
    logic [WW-1:0]     w;
    logic [WW-1:0]     h;
    logic [AW-1:0]     col;
    logic [AW-1:0]     n_col;
    logic [RW-1:0]     n_row;
    logic              end_col;
    logic              end_row;
    logic              emit;
    t_pred_mode        mode;
    t_lbuf_ctl         lbuf_ctl;
    t_pix              tl;
    t_pix              tr;
    t_pix              bl;
    t_pix              pred;

    assign i_pix.ready = !r_out_vld || o_pred.ready;
    assign accept      = i_pix.valid && i_pix.ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_x       <= 1'b0;
            r_half_y       <= 1'b0;
            r_avg_cur      <= 1'b0;
            r_resid        <= 1'b0;
            r_block_width  <= BLOCK_SIZE_RST;
            r_block_height <= BLOCK_SIZE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_HALF_X:       r_half_x       <= i_cfg_data[0];
                CFG_HALF_Y:       r_half_y       <= i_cfg_data[0];
                CFG_AVG_CUR:      r_avg_cur      <= i_cfg_data[0];
                CFG_RESID_MODE:   r_resid        <= i_cfg_data[0];
                CFG_BLOCK_WIDTH:  r_block_width  <= i_cfg_data;
                CFG_BLOCK_HEIGHT: r_block_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Effective window size and position
    always_comb begin
        hx = r_half_x && !r_resid;
        hy = r_half_y && !r_resid;

        if (r_block_width == '0) begin
            bw = WW'(1);
        end else if (WW'(r_block_width) > WW'(MAX_WIDTH)) begin
            bw = WW'(MAX_WIDTH);
        end else begin
            bw = WW'(r_block_width);
        end

        if (r_block_height == '0) begin
            bh = WW'(1);
        end else if (WW'(r_block_height) > WW'(MAX_HEIGHT)) begin
            bh = WW'(MAX_HEIGHT);
        end else begin
            bh = WW'(r_block_height);
        end

        w = bw + WW'(hx);
        h = bh + WW'(hy);

        if (WW'(r_col) > WW'(MAX_WIDTH)) begin
            col = AW'(MAX_WIDTH);
        end else begin
            col = r_col;
        end

        end_col = WW'(col) >= (w - WW'(1));
        end_row = WW'(r_row) >= (h - WW'(1));
        emit    = (!hx || (col != '0)) && (!hy || (r_row != '0));

        n_col = end_col ? '0 : col + AW'(1);
        if (!end_col) begin
            n_row = r_row;
        end else if (end_row) begin
            n_row = '0;
        end else begin
            n_row = r_row + RW'(1);
        end
    end

    // Window counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign lbuf_ctl = '{step: accept, nonres: !r_resid, end_col: end_col};

    hpmc_lbuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_lbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (lbuf_ctl),
        .i_col      (col),
        .i_col_next (n_col),
        .i_ref      (i_pix.ref_pixel),
        .o_tl       (tl),
        .o_tr       (tr),
        .o_bl       (bl)
    );

    assign mode = '{half_x: hx, half_y: hy, avg_cur: r_avg_cur, resid: r_resid};

    hpmc_pred u_pred (
        .i_mode     (mode),
        .i_tl       (tl),
        .i_tr       (tr),
        .i_bl       (bl),
        .i_ref      (i_pix.ref_pixel),
        .i_cur      (i_pix.current_pixel),
        .i_residual (i_pix.residual),
        .o_pred     (pred)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (accept) begin
            r_out_vld <= emit;
        end else if (o_pred.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_pred <= pred;
            r_last <= end_col && end_row;
        end
    end

    assign o_pred.valid      = r_out_vld;
    assign o_pred.pred_pixel = r_pred;
    assign o_pred.block_last = r_last;

endmodule

>>> rtl/core/hpmc_checker.sv
`include "half_pel_motion_compensation_defines.svh"

module hpmc_checker
    import hpmc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_pix i_out_pixel,
    input logic i_out_last
);

    // A stalled result holds
    `HPMC_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_pixel) && $stable(i_out_last)), "result changed while stalled")

    // Requests flow whenever the output register is free or draining
    `HPMC_ASSERT(a_in_ready, i_clk, i_rst_n, (!i_out_valid || i_out_ready) |-> i_in_ready, "request stalled with room in output")

    // A new result only follows an accepted request
    `HPMC_ASSERT(a_out_cause, i_clk, i_rst_n, $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready), "result without request")

    // Reset empties the output
    `HPMC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind half_pel_motion_compensation hpmc_checker u_hpmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pred.valid),
    .i_out_ready (o_pred.ready),
    .i_out_pixel (o_pred.pred_pixel),
    .i_out_last  (o_pred.block_last)
);
